[hdl/dogse_pkg.sv]
// Shared types and constants for the depth outlier-gated estimator.
// Used by the divider, square-root unit and top level; no dependencies.
`default_nettype none
package dogse_pkg;

    localparam int DEPTH_W = 13;
    localparam int MEAN_W  = 21;   // Q13.8 mm
    localparam int SQ_W    = 44;   // Q36.8
    localparam int CNT_W   = 10;
    localparam int WC_W    = 8;
    localparam int ACC_PW  = 7;
    localparam int EST_W   = 10;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 2;

    localparam int DIV_W   = 44;   // dividend / quotient width
    localparam int DVS_W   = 12;   // divisor width
    localparam int RAD_W   = 52;   // square-root radicand width
    localparam int ROOT_W  = 26;

    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [MEAN_W-1:0]  mean_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam depth_t DEPTH_LO  = 13'd100;
    localparam depth_t DEPTH_HI  = 13'd7000;
    localparam count_t COUNT_MAX = 10'd1023;
    // ceil(2^18 / 5): exact divide by five for 16-bit operands
    localparam logic [15:0] FIFTH_RECIP = 16'd52429;

    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_WSTORED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_WDONE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUTLIER  = 3'd4;
    localparam logic [STAT_W-1:0] ST_RESTART  = 3'd5;

    localparam logic [IDX_W-1:0] REG_WARMUP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_ACCURACY = 2'd1;

endpackage
`default_nettype wire

[hdl/depth_outlier_gated_estimator.sv]
// Top level of the depth outlier-gated estimator: sample store, sequencer, statistics.
// Depends on dogse_pkg, dogse_div and dogse_sqrt.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid/in_ready   | depth_x_mm, depth_y_mm, rotating
//  out     | output    | out_valid/out_ready | status, chosen_depth_mm, mean_mm, ...
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. Ignored, stored or outlier beats go from evaluation straight to the
// final state. Accepted beats run two divides and a root. The beat that ends the warm-up
// sweeps the sample memory twice.
// Reset clears statistics; the sample memory is not cleared. A stalled output beat holds
// the sequencer in its final state; no input beat is taken meanwhile.
`default_nettype none
module depth_outlier_gated_estimator
    import dogse_pkg::*;
#(
    parameter int WARMUP_MAX = 128
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DEPTH_W-1:0] depth_x_mm,
    input  wire logic [DEPTH_W-1:0] depth_y_mm,
    input  wire logic               rotating,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [STAT_W-1:0]       status,
    output logic [DEPTH_W-1:0]      chosen_depth_mm,
    output logic [DEPTH_W-1:0]      mean_mm,
    output logic [DEPTH_W-1:0]      deviation_mm,
    output logic                    converged,
    output logic [EST_W-1:0]        estimate_cm,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [WC_W-1:0]    cfg_data
);
    localparam int AW    = $clog2(WARMUP_MAX);
    localparam int ACC_W = 2 * MEAN_W + AW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_MDIV  = 4'd3;
    localparam logic [3:0] S_SQS   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ADIV  = 4'd6;
    localparam logic [3:0] S_SQT   = 4'd7;
    localparam logic [3:0] S_SQADD = 4'd8;
    localparam logic [3:0] S_DEV   = 4'd9;
    localparam logic [3:0] S_DDIV  = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_CONV  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0]        state_reg, state_next;
    count_t            count_reg, count_next;
    mean_t             mean_reg, mean_next;
    sq_t               sq_reg, sq_next;
    mean_t             dev_reg, dev_next;
    logic              conv_reg, conv_next;
    logic [EST_W-1:0]  est_reg, est_next;
    logic [WC_W-1:0]   wcfg_reg, wcfg_next;
    logic [ACC_PW-1:0] accp_reg, accp_next;
    logic              warm_reg, warm_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              ov_reg, ov_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rv_reg, rv_next;
    logic              pv_reg, pv_next;

    depth_t            d_reg, d_next;
    logic [WC_W-1:0]   w_reg, w_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2*MEAN_W-1:0] prod_reg, prod_next;
    logic [STAT_W-1:0] o_stat_reg, o_stat_next;
    depth_t            o_d_reg, o_d_next;
    depth_t            o_mean_reg, o_mean_next;
    depth_t            o_dev_reg, o_dev_next;
    logic              o_conv_reg, o_conv_next;
    logic [EST_W-1:0]  o_est_reg, o_est_next;

    // sample memory
    depth_t            mem [WARMUP_MAX];
    depth_t            rd_data_reg;
    logic              mem_we;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_a, div_q;
    logic [DVS_W-1:0]  div_b;
    logic              sqrt_start, sqrt_done;
    logic [RAD_W-1:0]  sqrt_in;
    logic [ROOT_W-1:0] sqrt_out;

    // combinational helpers
    logic              x_ok, y_ok, d_ok;
    depth_t            ad, pick;
    logic [15:0]       ad5;
    logic [13:0]       xy_sum;
    mean_t             dq, diff, diff2;
    logic [WC_W-1:0]   w_eff;
    count_t            n_val, nm1;
    logic [MEAN_W:0]   diff_x2;
    logic [MEAN_W+2:0] dev_x5;
    logic [27:0]       lhs_conv, rhs_conv;
    logic [SQ_W:0]     sq_sum;
    logic [ACC_W-1:0]  acc_sh;
    logic [CNT_W:0]    w_x3;
    logic [27:0]       est_prod;

    dogse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    dogse_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_out)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // depth selection on the incoming beat
    always_comb
    begin
        x_ok   = (depth_x_mm > DEPTH_LO) && (depth_x_mm < DEPTH_HI);
        y_ok   = (depth_y_mm > DEPTH_LO) && (depth_y_mm < DEPTH_HI);
        ad     = (depth_x_mm > depth_y_mm) ? depth_x_mm - depth_y_mm
                                           : depth_y_mm - depth_x_mm;
        ad5    = ({3'b0, ad} << 2) + {3'b0, ad};
        xy_sum = {1'b0, depth_x_mm} + {1'b0, depth_y_mm};
        if (x_ok && y_ok)
        begin
            if (!rotating)
                pick = depth_y_mm;
            else if (ad5 < {3'b0, depth_x_mm} && ad5 < {3'b0, depth_y_mm})
                pick = xy_sum[13:1];
            else
                pick = (depth_x_mm > depth_y_mm) ? depth_x_mm : depth_y_mm;
        end
        else if (x_ok)
            pick = depth_x_mm;
        else
            pick = depth_y_mm;
        w_eff = ({3'b0, wcfg_reg} > 11'(WARMUP_MAX)) ? WC_W'(WARMUP_MAX) : wcfg_reg;
    end

    always_comb
    begin
        d_ok     = (d_reg > DEPTH_LO) && (d_reg < DEPTH_HI);
        dq       = {d_reg, 8'b0};
        diff     = (dq > mean_reg) ? dq - mean_reg : mean_reg - dq;
        diff_x2  = {diff, 1'b0};
        dev_x5   = ({2'b0, dev_reg, 1'b0} << 1) + {3'b0, dev_reg};
        n_val    = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        nm1      = n_val - 1'b1;
        diff2    = ({rd_data_reg, 8'b0} > mean_reg) ? {rd_data_reg, 8'b0} - mean_reg
                                                    : mean_reg - {rd_data_reg, 8'b0};
        lhs_conv = 28'(dev_reg) * 28'd100;
        rhs_conv = 28'(mean_reg) * 28'(accp_reg);
        sq_sum   = {1'b0, sq_reg} + (SQ_W+1)'(prod_reg >> 8);
        acc_sh   = acc_reg >> 8;
        w_x3     = ({3'b0, w_reg} << 1) + {3'b0, w_reg};
        // mean / 2560 = (mean / 512) / 5, the divide by five by reciprocal
        est_prod = 28'(mean_reg[MEAN_W-1:9]) * 28'(FIFTH_RECIP);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        mean_next   = mean_reg;
        sq_next     = sq_reg;
        dev_next    = dev_reg;
        conv_next   = conv_reg;
        est_next    = est_reg;
        wcfg_next   = wcfg_reg;
        accp_next   = accp_reg;
        warm_next   = warm_reg;
        stat_next   = stat_reg;
        ov_next     = ov_reg;
        idx_next    = idx_reg;
        rv_next     = 1'b0;
        pv_next     = 1'b0;
        d_next      = d_reg;
        w_next      = w_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        o_stat_next = o_stat_reg;
        o_d_next    = o_d_reg;
        o_mean_next = o_mean_reg;
        o_dev_next  = o_dev_reg;
        o_conv_next = o_conv_reg;
        o_est_next  = o_est_reg;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        div_a       = '0;
        div_b       = '0;
        sqrt_start  = 1'b0;
        sqrt_in     = {div_q[RAD_W-9:0], 8'b0};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WARMUP:   wcfg_next = cfg_data;
                REG_ACCURACY: accp_next = cfg_data[ACC_PW-1:0];
                default:      ;
            endcase
        end

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    d_next     = pick;
                    w_next     = w_eff;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                warm_next = 1'b0;
                if (!d_ok)
                begin
                    stat_next  = ST_IGNORED;
                    state_next = S_FIN;
                end
                else if (count_reg < CNT_W'(w_reg))
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg + 1'b1 == CNT_W'(w_reg))
                    begin
                        stat_next  = ST_WDONE;
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        stat_next  = ST_WSTORED;
                        state_next = S_FIN;
                    end
                end
                else if (dev_reg == '0 || (MEAN_W+3)'(diff_x2) > dev_x5)
                begin
                    stat_next  = ST_OUTLIER;
                    state_next = S_FIN;
                end
                else
                begin
                    mem_we     = ({1'b0, count_reg} < (CNT_W+1)'(WARMUP_MAX));
                    prod_next  = (2*MEAN_W)'(31'(mean_reg) * 31'(nm1));
                    count_next = n_val;
                    stat_next  = ST_ACCEPTED;
                    state_next = S_MUL;
                end
            end
            S_SUM:
            begin
                if (idx_reg < CNT_W'(w_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                    acc_next = acc_reg + ACC_W'(rd_data_reg);
                if (idx_reg == CNT_W'(w_reg) && !rv_reg)
                begin
                    div_start  = 1'b1;
                    div_a      = {acc_reg[DIV_W-9:0], 8'b0};
                    div_b      = DVS_W'(w_reg);
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_q[MEAN_W-1:0];
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_SQS;
                end
            end
            S_SQS:
            begin
                if (idx_reg < CNT_W'(w_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    prod_next = (2*MEAN_W)'(diff2) * (2*MEAN_W)'(diff2);
                    pv_next   = 1'b1;
                end
                if (pv_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                if (idx_reg == CNT_W'(w_reg) && !rv_reg && !pv_reg)
                begin
                    sq_next    = (acc_sh > ACC_W'({SQ_W{1'b1}})) ? {SQ_W{1'b1}}
                                                                : acc_sh[SQ_W-1:0];
                    warm_next  = 1'b1;
                    state_next = S_DEV;
                end
            end
            S_MUL:
            begin
                div_start  = 1'b1;
                div_a      = DIV_W'(prod_reg) + DIV_W'(dq);
                div_b      = DVS_W'(count_reg);
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_q[MEAN_W-1:0];
                    state_next = S_SQT;
                end
            end
            S_SQT:
            begin
                prod_next  = (2*MEAN_W)'(diff) * (2*MEAN_W)'(diff);
                state_next = S_SQADD;
            end
            S_SQADD:
            begin
                sq_next    = sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
                state_next = S_DEV;
            end
            S_DEV:
            begin
                if (count_reg <= CNT_W'(1))
                begin
                    dev_next   = '0;
                    state_next = warm_reg ? S_FIN : S_CONV;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = sq_reg;
                    div_b      = DVS_W'(count_reg - 1'b1);
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    dev_next   = (|sqrt_out[ROOT_W-1:MEAN_W]) ? {MEAN_W{1'b1}}
                                                             : sqrt_out[MEAN_W-1:0];
                    state_next = warm_reg ? S_FIN : S_CONV;
                end
            end
            S_CONV:
            begin
                if (lhs_conv <= rhs_conv)
                begin
                    conv_next  = 1'b1;
                    est_next   = est_prod[27:18];
                    state_next = S_FIN;
                end
                else
                begin
                    if ({1'b0, count_reg} > w_x3)
                    begin
                        count_next = '0;
                        mean_next  = '0;
                        sq_next    = '0;
                        dev_next   = '0;
                        stat_next  = ST_RESTART;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    o_stat_next = stat_reg;
                    o_d_next    = d_reg;
                    o_mean_next = mean_reg[MEAN_W-1:8];
                    o_dev_next  = dev_reg[MEAN_W-1:8];
                    o_conv_next = conv_reg;
                    o_est_next  = est_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= d_reg;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mean_reg  <= '0;
            sq_reg    <= '0;
            dev_reg   <= '0;
            conv_reg  <= 1'b0;
            est_reg   <= '0;
            wcfg_reg  <= 8'd101;
            accp_reg  <= 7'd10;
            warm_reg  <= 1'b0;
            stat_reg  <= ST_IGNORED;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mean_reg  <= mean_next;
            sq_reg    <= sq_next;
            dev_reg   <= dev_next;
            conv_reg  <= conv_next;
            est_reg   <= est_next;
            wcfg_reg  <= wcfg_next;
            accp_reg  <= accp_next;
            warm_reg  <= warm_next;
            stat_reg  <= stat_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            rv_reg    <= rv_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        o_stat_reg <= o_stat_next;
        o_d_reg    <= o_d_next;
        o_mean_reg <= o_mean_next;
        o_dev_reg  <= o_dev_next;
        o_conv_reg <= o_conv_next;
        o_est_reg  <= o_est_next;
    end

    assign out_valid       = ov_reg;
    assign status          = o_stat_reg;
    assign chosen_depth_mm = o_d_reg;
    assign mean_mm         = o_mean_reg;
    assign deviation_mm    = o_dev_reg;
    assign converged       = o_conv_reg;
    assign estimate_cm     = o_est_reg;

    // convergence is sticky until reset
    a_conv_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(conv_reg))
        else $error("converged flag dropped");

    // fewer than two samples means no spread
    a_dev_small: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg < CNT_W'(2)) |-> dev_reg == '0)
        else $error("nonzero deviation with fewer than two samples");

    // sample count only drops on a restart
    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |-> (count_reg == '0))
        else $error("sample count dropped without restart");

    // the sample memory is written only while evaluating a beat
    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EVAL))
        else $error("sample memory written outside evaluation");

endmodule
`default_nettype wire

[hdl/dogse_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on dogse_pkg for widths.
`default_nettype none
module dogse_div
    import dogse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(rem_sh - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

[hdl/dogse_sqrt.sv]
// Integer square root, one result bit per cycle (digit-by-digit method).
// Depends on dogse_pkg for widths.
`default_nettype none
module dogse_sqrt
    import dogse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RAD_W-1:0] radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);
    localparam int CW = $clog2(RAD_W / 2 + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [RAD_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(RAD_W / 2);
            v_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(RAD_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = RAD_W'({1'b0, v_reg} - trial);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

[verif/tb_depth_outlier_gated_estimator.sv]
// Self-checking testbench for depth_outlier_gated_estimator: directed and random beats
// checked against a predictor of the estimator. Depends on dogse_pkg and the top level.
`timescale 1ns / 1ps
module tb_depth_outlier_gated_estimator;
    import dogse_pkg::*;

    localparam int SAMPLE_MAX  = 128;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        depth_t            chosen;
        depth_t            mean;
        depth_t            dev;
        logic              conv;
        logic [EST_W-1:0]  est;
    } depth_report_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    depth_t             depth_x_mm;
    depth_t             depth_y_mm;
    logic               rotating;
    logic               out_valid;
    logic               out_ready;
    logic [STAT_W-1:0]  status;
    depth_t             chosen_depth_mm;
    depth_t             mean_mm;
    depth_t             deviation_mm;
    logic               converged;
    logic [EST_W-1:0]   estimate_cm;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [WC_W-1:0]    cfg_data;

    depth_outlier_gated_estimator #(.WARMUP_MAX(SAMPLE_MAX)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .depth_x_mm(depth_x_mm), .depth_y_mm(depth_y_mm), .rotating(rotating),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .chosen_depth_mm(chosen_depth_mm), .mean_mm(mean_mm),
        .deviation_mm(deviation_mm), .converged(converged), .estimate_cm(estimate_cm),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    depth_t          sample_mem [SAMPLE_MAX];
    int unsigned     n_samples;
    longint unsigned mean_q;
    longint unsigned sq_sum;
    longint unsigned dev_q;
    bit              conv_flag;
    int unsigned     est_store;
    int unsigned     warm_cfg;
    int unsigned     acc_cfg;

    depth_report_t   pending_reports[$];
    int              mismatches;
    int              beats_in;
    int              beats_out;
    int              status_seen [8];
    int              cycle_count;
    int              sink_hold;
    bit              no_idle;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic bit in_band(int unsigned d);
        return d > 100 && d < 7000;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void refresh_deviation(int unsigned n);
        longint unsigned r;
        if (n <= 1)
            dev_q = 0;
        else
        begin
            r = root_floor((sq_sum / (n - 1)) << 8);
            dev_q = (r > 64'h1F_FFFF) ? 64'h1F_FFFF : r;
        end
    endfunction

    function automatic depth_report_t estimate_depth(depth_t x, depth_t y, logic rot);
        depth_report_t   r;
        int unsigned     w;
        int unsigned     d;
        int unsigned     ad;
        int unsigned     n;
        logic [STAT_W-1:0] st;
        longint unsigned dq;
        longint unsigned df;
        longint unsigned sum;
        longint unsigned sq;
        longint unsigned s;
        w = (warm_cfg > SAMPLE_MAX) ? SAMPLE_MAX : warm_cfg;
        if (in_band(x) && in_band(y))
        begin
            if (!rot)
                d = y;
            else
            begin
                ad = (x > y) ? x - y : y - x;
                if (5 * ad < x && 5 * ad < y)
                    d = (x + y) >> 1;
                else
                    d = (x > y) ? x : y;
            end
        end
        else if (in_band(x))
            d = x;
        else
            d = y;
        dq = longint'(d) << 8;

        if (!in_band(d))
            st = ST_IGNORED;
        else if (n_samples < w)
        begin
            sample_mem[n_samples % SAMPLE_MAX] = depth_t'(d);
            n_samples++;
            st = ST_WSTORED;
            if (n_samples == w)
            begin
                sum = 0;
                sq = 0;
                for (int i = 0; i < w; i++) sum += sample_mem[i];
                mean_q = (sum << 8) / w;
                for (int i = 0; i < w; i++)
                begin
                    s = longint'(sample_mem[i]) << 8;
                    df = (s > mean_q) ? s - mean_q : mean_q - s;
                    sq += df * df;
                end
                sq >>= 8;
                sq_sum = (sq > 64'hFFF_FFFF_FFFF) ? 64'hFFF_FFFF_FFFF : sq;
                refresh_deviation(w);
                st = ST_WDONE;
            end
        end
        else
        begin
            df = (dq > mean_q) ? dq - mean_q : mean_q - dq;
            if (dev_q == 0 || 2 * df > 5 * dev_q)
                st = ST_OUTLIER;
            else
            begin
                n = (n_samples + 1 > 1023) ? 1023 : n_samples + 1;
                if (n_samples < SAMPLE_MAX) sample_mem[n_samples] = depth_t'(d);
                mean_q = (mean_q * (n - 1) + dq) / n;
                df = (dq > mean_q) ? dq - mean_q : mean_q - dq;
                sq_sum += (df * df) >> 8;
                if (sq_sum > 64'hFFF_FFFF_FFFF) sq_sum = 64'hFFF_FFFF_FFFF;
                n_samples = n;
                refresh_deviation(n);
                st = ST_ACCEPTED;
                if (dev_q * 100 <= mean_q * acc_cfg)
                begin
                    conv_flag = 1'b1;
                    est_store = (mean_q / 2560) & 10'h3FF;
                end
                else if (n_samples > 3 * w)
                begin
                    n_samples = 0;
                    mean_q = 0;
                    sq_sum = 0;
                    dev_q = 0;
                    st = ST_RESTART;
                end
            end
        end
        r.status = st;
        r.chosen = depth_t'(d);
        r.mean   = depth_t'(mean_q >> 8);
        r.dev    = depth_t'(dev_q >> 8);
        r.conv   = conv_flag;
        r.est    = est_store[EST_W-1:0];
        return r;
    endfunction

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_depth(depth_t x, depth_t y, logic rot);
        int gap;
        depth_report_t rpt;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        depth_x_mm <= x;
        depth_y_mm <= y;
        rotating   <= rot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        rpt = estimate_depth(x, y, rot);
        pending_reports.insert(pending_reports.size(), rpt);
        beats_in++;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [WC_W-1:0] value);
        drain_reports();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_WARMUP)
            warm_cfg = value;
        else if (idx == REG_ACCURACY)
            acc_cfg = value & 8'h7F;
    endtask

    function automatic depth_t near_depth(int c, int s);
        int v;
        v = c - s + int'($urandom_range(0, 2 * s));
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
        return depth_t'(v);
    endfunction

    function automatic depth_t edge_depth();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'd99;
            2: return 13'd100;
            3: return 13'd101;
            4: return 13'd6999;
            5: return 13'd7000;
            6: return 13'd7001;
            default: return 13'd8191;
        endcase
    endfunction

    // mostly well-formed beats that follow the running statistics, with some noise
    task automatic random_depths(int count, int centre, int spread);
        int     c;
        int     s;
        int     w;
        depth_t d;
        for (int k = 0; k < count; k++)
        begin
            w = (warm_cfg > SAMPLE_MAX) ? SAMPLE_MAX : warm_cfg;
            c = centre;
            s = spread;
            if (n_samples >= w && mean_q != 0)
            begin
                c = int'(mean_q >> 8);
                s = int'(dev_q >> 7) + 3;
            end
            if (c < 200) c = 200;
            if (c > 6800) c = 6800;
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_depth(depth_t'($urandom_range(0, 8191)),
                               depth_t'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
                else
                    send_depth(edge_depth(), edge_depth(), 1'($urandom_range(0, 1)));
            end
            else
            begin
                d = near_depth(c, s);
                case ($urandom_range(0, 7))
                    0: send_depth(d, edge_depth(), 1'($urandom_range(0, 1)));
                    1, 2, 3: send_depth(near_depth(d, d / 12), near_depth(d, d / 12), 1'b1);
                    default: send_depth(depth_t'($urandom_range(0, 8191)), d, 1'b0);
                endcase
            end
        end
    endtask

    task automatic test_selection_edges();
        write_reg(REG_WARMUP, 8'd2);
        write_reg(REG_ACCURACY, 8'd10);
        send_depth(13'd0, 13'd0, 1'b0);
        send_depth(13'd8191, 13'd8191, 1'b1);
        send_depth(13'd100, 13'd100, 1'b0);
        send_depth(13'd7000, 13'd50, 1'b1);
        send_depth(13'd101, 13'd0, 1'b0);       // only x in range
        send_depth(13'd7000, 13'd6999, 1'b1);   // only y in range, ends warm-up
        send_depth(13'd3000, 13'd3200, 1'b1);   // readings agree: average
        send_depth(13'd3000, 13'd5000, 1'b1);   // disagree: larger one
        send_depth(13'd4000, 13'd3500, 1'b0);   // not rotating: y
        send_depth(13'd5000, 13'd3000, 1'b1);
        send_depth(13'd101, 13'd101, 1'b1);     // far from the mean, but accepted; triggers a restart
        send_depth(13'd6999, 13'd6999, 1'b0);
        send_depth(13'd3500, 13'd3500, 1'b1);
        send_depth(13'd2000, 13'd8191, 1'b1);
        send_depth(13'd0, 13'd3600, 1'b0);
        send_depth(13'd3400, 13'd3300, 1'b0);
    endtask

    task automatic test_tiny_warmup();
        write_reg(REG_WARMUP, 8'd1);
        for (int k = 0; k < 6; k++) send_depth(13'd0, near_depth(2000, 300), 1'b0);
        write_reg(REG_WARMUP, 8'd0);
        for (int k = 0; k < 6; k++) send_depth(near_depth(2000, 300), 13'd0, 1'b1);
    endtask

    task automatic test_random_settings();
        write_reg(REG_WARMUP, 8'd255);          // clamps to the store depth
        write_reg(REG_ACCURACY, 8'd127);
        random_depths(170, $urandom_range(300, 6500), 200);
        write_reg(REG_WARMUP, 8'd2);
        write_reg(REG_ACCURACY, 8'd0);          // never converges: restarts
        random_depths(60, $urandom_range(300, 6500), 150);
        write_reg(REG_WARMUP, 8'd16);
        write_reg(REG_ACCURACY, 8'd100);
        random_depths(50, $urandom_range(300, 6500), 400);
        no_idle = 1'b1;
        write_reg(REG_WARMUP, 8'd5);
        write_reg(REG_ACCURACY, 8'd1);
        random_depths(40, $urandom_range(300, 6500), 80);
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        write_reg(REG_WARMUP, 8'd4);
        write_reg(REG_ACCURACY, 8'd10);
        sink_hold = 400;
        random_depths(30, $urandom_range(300, 6500), 100);
    endtask

    // sink: per-beat random stall plus the long hold-off
    initial
    begin
        int sink_gap;
        sink_gap = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sink_gap = idle_draw();
            if (sink_hold > 0)
            begin
                out_ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gap > 0)
            begin
                out_ready <= 1'b0;
                sink_gap--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        depth_report_t got;
        depth_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, chosen_depth_mm, mean_mm, deviation_mm, converged, estimate_cm};
            beats_out++;
            status_seen[status]++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: status %0d depth %0d", status, chosen_depth_mm);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("beat %0d mismatch: exp st %0d d %0d m %0d dev %0d c %0d e %0d",
                                 beats_out, want.status, want.chosen, want.mean, want.dev,
                                 want.conv, want.est);
                        $display("    got st %0d d %0d m %0d dev %0d c %0d e %0d",
                                 got.status, got.chosen, got.mean, got.dev, got.conv,
                                 got.est);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("depth_outlier_gated_estimator test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        depth_x_mm = '0;
        depth_y_mm = '0;
        rotating   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_WARMUP;
        cfg_data   = '0;
        n_samples  = 0;
        mean_q     = 0;
        sq_sum     = 0;
        dev_q      = 0;
        conv_flag  = 1'b0;
        est_store  = 0;
        warm_cfg   = 101;
        acc_cfg    = 10;
        mismatches = 0;
        beats_in   = 0;
        beats_out  = 0;
        cycle_count = 0;
        sink_hold  = 0;
        no_idle    = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_selection_edges();
        test_tiny_warmup();
        test_random_settings();
        test_output_stall();
        drain_reports();

        $display("%0d beats in, %0d out; ignored %0d, warm-up %0d/%0d, accepted %0d,",
                 beats_in, beats_out, status_seen[ST_IGNORED], status_seen[ST_WSTORED],
                 status_seen[ST_WDONE], status_seen[ST_ACCEPTED]);
        $display("outliers %0d, restarts %0d, mismatches %0d",
                 status_seen[ST_OUTLIER], status_seen[ST_RESTART], mismatches);
        if (mismatches == 0)
            $display("depth_outlier_gated_estimator test passed");
        else
            $display("depth_outlier_gated_estimator test failed");
        $finish;
    end

endmodule
